// ===== rtl/cvtp_pkg.sv =====
// Shared types and constants of the constant-velocity track predictor.
package cvtp_pkg;

    localparam int MAX_OBJECTS_DEFAULT = 16;

    localparam int OBJ_W      = 4;
    localparam int POS_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int OFS_W      = 48;
    localparam int VEL_W      = 32;
    localparam int KEEP_W     = 8;
    localparam int CNT_W      = 2;
    localparam int FRAC_W     = 16;
    localparam int QUOT_W     = 32;
    localparam int NUMER_W    = QUOT_W + FRAC_W + 1;
    localparam int PROD_W     = 64;
    localparam int SUM_W      = OFS_W + 2;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_KEEP_EVERY = 1'b0;

    localparam logic [KEEP_W-1:0] KEEP_EVERY_RESET = KEEP_W'(1);
    localparam logic [KEEP_W-1:0] SKIP_MAX         = '1;
    localparam logic [CNT_W-1:0]  COUNT_FULL       = CNT_W'(2);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [VEL_W-1:0]  VEL_POS_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0]  VEL_NEG_MAG = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic [OFS_W-1:0]  OFS_MAX     = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic [OFS_W-1:0]  OFS_MIN     = {1'b1, {(OFS_W-1){1'b0}}};

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_ONE_SAMPLE = 2'd1,
        STATUS_EQUAL_TIME = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DELTA_T,
        ST_AXIS,
        ST_SCALE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MULTIPLY,
        ST_ROUND,
        ST_OFFSET,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic [STAMP_W-1:0] stamp;
    } sample_t;

    typedef struct packed {
        logic [KEEP_W-1:0] skip_count;
        logic [CNT_W-1:0]  sample_count;
        sample_t           older;
        sample_t           newer;
    } obj_word_t;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } div_res_t;

endpackage

// ===== rtl/const_velocity_track_predictor_core.sv =====
// Top level of the constant-velocity track predictor: configuration port, sequencer and datapath.
//
// Each pose sample transfer is handled alone; sample_stall stays high until the sample is done.
// A sample whose object index is out of range is dropped, a skipped sample passes ST_READ only, and a
// kept sample with fewer than two samples or equal timestamps goes from ST_READ to ST_FINISH. In a
// full fit each of the three axes passes set-up, the shared radix-2 divider that yields one velocity
// bit per cycle, one 32x32 multiply, rounding and the saturating offset add. The result is held in an
// output register, so the next sample can be taken while a result still waits to be transferred.
// Per-object state lives in one memory of MAX_OBJECTS words with a registered read port; a valid bit
// per object makes it read as cleared after reset, so no clearing pass is needed. keep_every lies at
// byte address 0.
module const_velocity_track_predictor_core #(
    parameter int MAX_OBJECTS = cvtp_pkg::MAX_OBJECTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cvtp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cvtp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cvtp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,

    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic [cvtp_pkg::OBJ_W-1:0]          object_index,
    input  logic signed [cvtp_pkg::POS_W-1:0]   pos_x,
    input  logic signed [cvtp_pkg::POS_W-1:0]   pos_y,
    input  logic signed [cvtp_pkg::POS_W-1:0]   pos_z,
    input  logic [cvtp_pkg::STAMP_W-1:0]        sample_time,

    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [cvtp_pkg::OBJ_W-1:0]          result_object,
    output logic [1:0]                          status,
    output logic signed [cvtp_pkg::OFS_W-1:0]   offset_x,
    output logic signed [cvtp_pkg::OFS_W-1:0]   offset_y,
    output logic signed [cvtp_pkg::OFS_W-1:0]   offset_z,
    output logic signed [cvtp_pkg::VEL_W-1:0]   velocity_x,
    output logic signed [cvtp_pkg::VEL_W-1:0]   velocity_y,
    output logic signed [cvtp_pkg::VEL_W-1:0]   velocity_z,
    output logic [cvtp_pkg::STAMP_W-1:0]        start_time,
    output logic [cvtp_pkg::STAMP_W-1:0]        end_time
);
    import cvtp_pkg::*;

    localparam int ADDR_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    // Configuration.
    logic [KEEP_W-1:0]  keep_every_reg;
    logic               reg_sel;
    logic               cfg_write;

    // Sequencer.
    seq_state_t         state_reg;
    seq_state_t         state_next;

    // Working registers.
    logic [OBJ_W-1:0]   item_obj_reg;
    sample_t            item_reg;
    sample_t            older_reg;
    status_t            status_reg;
    logic               dt_neg_reg;
    logic [QUOT_W-1:0]  dt_mag_reg;
    logic [1:0]         axis_reg;
    logic               dq_neg_reg;
    logic [QUOT_W-1:0]  dq_mag_reg;
    logic [NUMER_W-1:0] numer_reg;
    logic               vel_neg_reg;
    logic [VEL_W-1:0]   vel_mag_reg;
    logic [VEL_W-1:0]   vel_reg [3];
    logic [PROD_W-1:0]  prod_reg;
    logic [OFS_W-1:0]   rounded_reg;
    logic [OFS_W-1:0]   off_reg [3];

    // Result registers.
    logic               result_valid_reg;
    logic [OBJ_W-1:0]   res_obj_reg;
    status_t            res_status_reg;
    logic [OFS_W-1:0]   res_off_reg [3];
    logic [VEL_W-1:0]   res_vel_reg [3];
    logic [STAMP_W-1:0] res_start_reg;
    logic [STAMP_W-1:0] res_end_reg;

    // Combinational datapath.
    logic               accept;
    logic               in_range;
    logic               rd_en;
    obj_word_t          rd_word;
    obj_word_t          wr_word;
    logic               wr_en;
    logic [KEEP_W-1:0]  skip_inc;
    logic [CNT_W-1:0]   count_inc;
    logic               keep;
    logic [POS_W-1:0]   q1_sel;
    logic [POS_W-1:0]   q2_sel;
    logic               div_start;
    div_res_t           div_res;
    logic               vel_neg;
    logic [VEL_W-1:0]   vel_mag;
    logic signed [SUM_W-1:0] q1_ext;
    logic signed [SUM_W-1:0] p_ext;
    logic signed [SUM_W-1:0] off_sum;
    logic [OFS_W-1:0]   off_sat;
    logic               finish_load;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[APB_ADDR_W-1] == REG_KEEP_EVERY;
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign prdata    = reg_sel ? APB_DATA_W'(keep_every_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_every_reg <= KEEP_EVERY_RESET;
        end
        else if (cfg_write)
        begin
            keep_every_reg <= pwdata[KEEP_W-1:0];
        end
    end

    // Input side.
    assign sample_stall = state_reg != ST_IDLE;
    assign accept       = sample_valid && (state_reg == ST_IDLE);
    assign in_range     = {{(32-OBJ_W){1'b0}}, object_index} < 32'(MAX_OBJECTS);
    assign rd_en        = accept && in_range;

    cvtp_obj_store #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .ADDR_W      (ADDR_W)
    ) u_obj_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(object_index)),
        .rd_word (rd_word),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(item_obj_reg)),
        .wr_word (wr_word)
    );

    cvtp_div_unit u_div_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer_reg),
        .denom (dt_mag_reg),
        .res   (div_res)
    );

    // Skip counter and sample bookkeeping.
    assign skip_inc  = (rd_word.skip_count == SKIP_MAX) ? SKIP_MAX : rd_word.skip_count + 1'b1;
    assign keep      = skip_inc >= keep_every_reg;
    assign count_inc = (rd_word.sample_count >= COUNT_FULL) ? COUNT_FULL
                                                           : rd_word.sample_count + 1'b1;
    assign wr_en     = state_reg == ST_READ;

    always_comb
    begin
        wr_word = rd_word;
        if (keep)
        begin
            wr_word.skip_count   = '0;
            wr_word.sample_count = count_inc;
            wr_word.older        = rd_word.newer;
            wr_word.newer        = item_reg;
        end
        else
        begin
            wr_word.skip_count = skip_inc;
        end
    end

    // Axis selection for the shared datapath.
    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                q1_sel = older_reg.pos_x;
                q2_sel = item_reg.pos_x;
            end
            AXIS_Y:
            begin
                q1_sel = older_reg.pos_y;
                q2_sel = item_reg.pos_y;
            end
            default:
            begin
                q1_sel = older_reg.pos_z;
                q2_sel = item_reg.pos_z;
            end
        endcase
    end

    // Velocity saturation from the divider result.
    assign vel_neg = dq_neg_reg ^ dt_neg_reg;

    always_comb
    begin
        if (vel_neg)
        begin
            if (div_res.ovf || (div_res.quot > VEL_NEG_MAG))
            begin
                vel_mag = VEL_NEG_MAG;
            end
            else
            begin
                vel_mag = div_res.quot;
            end
        end
        else
        begin
            if (div_res.ovf || div_res.quot[QUOT_W-1])
            begin
                vel_mag = VEL_POS_MAX;
            end
            else
            begin
                vel_mag = div_res.quot;
            end
        end
    end

    // Offset add with saturation to the output width.
    assign q1_ext  = SUM_W'($signed(q1_sel));
    assign p_ext   = $signed({2'b00, rounded_reg});
    assign off_sum = vel_neg_reg ? q1_ext + p_ext : q1_ext - p_ext;

    always_comb
    begin
        if ((off_sum[SUM_W-1] == off_sum[OFS_W-1]) && (off_sum[SUM_W-2] == off_sum[OFS_W-1]))
        begin
            off_sat = off_sum[OFS_W-1:0];
        end
        else if (off_sum[SUM_W-1])
        begin
            off_sat = OFS_MIN;
        end
        else
        begin
            off_sat = OFS_MAX;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        div_start   = 1'b0;
        finish_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!keep)
                begin
                    state_next = ST_IDLE;
                end
                else if (count_inc < COUNT_FULL)
                begin
                    state_next = ST_FINISH;
                end
                else if (rd_word.newer.stamp == item_reg.stamp)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_DELTA_T;
                end
            end
            ST_DELTA_T:
            begin
                state_next = ST_AXIS;
            end
            ST_AXIS:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = ST_MULTIPLY;
                end
            end
            ST_MULTIPLY:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_OFFSET;
            end
            ST_OFFSET:
            begin
                state_next = (axis_reg == AXIS_Z) ? ST_FINISH : ST_AXIS;
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    finish_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_obj_reg   <= object_index;
            item_reg.pos_x <= pos_x;
            item_reg.pos_y <= pos_y;
            item_reg.pos_z <= pos_z;
            item_reg.stamp <= sample_time;
        end

        if (state_reg == ST_READ)
        begin
            older_reg <= rd_word.newer;
            if (count_inc < COUNT_FULL)
            begin
                status_reg <= STATUS_ONE_SAMPLE;
            end
            else if (rd_word.newer.stamp == item_reg.stamp)
            begin
                status_reg <= STATUS_EQUAL_TIME;
            end
            else
            begin
                status_reg <= STATUS_OK;
            end
        end

        if (state_reg == ST_DELTA_T)
        begin
            dt_neg_reg <= item_reg.stamp < older_reg.stamp;
            dt_mag_reg <= (item_reg.stamp < older_reg.stamp) ? older_reg.stamp - item_reg.stamp
                                                             : item_reg.stamp - older_reg.stamp;
        end

        if (state_reg == ST_AXIS)
        begin
            dq_neg_reg <= $signed(q2_sel) < $signed(q1_sel);
            dq_mag_reg <= ($signed(q2_sel) < $signed(q1_sel)) ? q1_sel - q2_sel : q2_sel - q1_sel;
        end

        if (state_reg == ST_SCALE)
        begin
            numer_reg <= NUMER_W'({dq_mag_reg, {FRAC_W{1'b0}}}) + NUMER_W'(dt_mag_reg >> 1);
        end

        if ((state_reg == ST_DIV_WAIT) && div_res.done)
        begin
            vel_neg_reg       <= vel_neg;
            vel_mag_reg       <= vel_mag;
            vel_reg[axis_reg] <= vel_neg ? VEL_W'(0) - vel_mag : vel_mag;
        end

        if (state_reg == ST_MULTIPLY)
        begin
            prod_reg <= PROD_W'(vel_mag_reg) * PROD_W'(older_reg.stamp);
        end

        if (state_reg == ST_ROUND)
        begin
            rounded_reg <= OFS_W'((prod_reg + ROUND_HALF) >> FRAC_W);
        end

        if (state_reg == ST_OFFSET)
        begin
            off_reg[axis_reg] <= off_sat;
        end

        if (finish_load)
        begin
            res_obj_reg    <= item_obj_reg;
            res_status_reg <= status_reg;
            res_end_reg    <= item_reg.stamp;
            if (status_reg == STATUS_ONE_SAMPLE)
            begin
                res_start_reg <= item_reg.stamp;
            end
            else
            begin
                res_start_reg <= older_reg.stamp;
            end
            for (int a = 0; a < 3; a++)
            begin
                if (status_reg == STATUS_OK)
                begin
                    res_off_reg[a] <= off_reg[a];
                    res_vel_reg[a] <= vel_reg[a];
                end
                else
                begin
                    res_off_reg[a] <= '0;
                    res_vel_reg[a] <= '0;
                end
            end
        end
    end

    // Axis counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= AXIS_X;
        end
        else if (state_reg == ST_DELTA_T)
        begin
            axis_reg <= AXIS_X;
        end
        else if ((state_reg == ST_OFFSET) && (axis_reg != AXIS_Z))
        begin
            axis_reg <= axis_reg + 1'b1;
        end
    end

    // Output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (finish_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid  = result_valid_reg;
    assign result_object = res_obj_reg;
    assign status        = res_status_reg;
    assign offset_x      = $signed(res_off_reg[0]);
    assign offset_y      = $signed(res_off_reg[1]);
    assign offset_z      = $signed(res_off_reg[2]);
    assign velocity_x    = $signed(res_vel_reg[0]);
    assign velocity_y    = $signed(res_vel_reg[1]);
    assign velocity_z    = $signed(res_vel_reg[2]);
    assign start_time    = res_start_reg;
    assign end_time      = res_end_reg;

endmodule

// ===== rtl/cvtp_div_unit.sv =====
// Radix-2 restoring divider producing one quotient bit per cycle.
module cvtp_div_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [cvtp_pkg::NUMER_W-1:0]    numer,
    input  logic [cvtp_pkg::QUOT_W-1:0]     denom,
    output cvtp_pkg::div_res_t              res
);
    import cvtp_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [QUOT_W-1:0]    rem_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [QUOT_W-1:0]    den_reg;
    logic                 ovf_reg;

    logic [QUOT_W:0]      trial;
    logic [QUOT_W:0]      diff;
    logic                 fits;
    logic [QUOT_W-1:0]    rem_next;
    logic [QUOT_W-1:0]    numer_hi;

    assign numer_hi = QUOT_W'(numer[NUMER_W-1:QUOT_W]);
    assign trial    = {rem_reg, quot_reg[QUOT_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign rem_next = fits ? diff[QUOT_W-1:0] : trial[QUOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= numer_hi;
            quot_reg <= numer[QUOT_W-1:0];
            den_reg  <= denom;
            ovf_reg  <= numer_hi >= denom;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;

endmodule

// ===== rtl/cvtp_obj_store.sv =====
// Per-object state memory with valid bits that read as a cleared entry after reset.
module cvtp_obj_store #(
    parameter int MAX_OBJECTS = cvtp_pkg::MAX_OBJECTS_DEFAULT,
    parameter int ADDR_W      = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output cvtp_pkg::obj_word_t  rd_word,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  cvtp_pkg::obj_word_t  wr_word
);
    import cvtp_pkg::*;

    obj_word_t              mem [MAX_OBJECTS];
    logic [MAX_OBJECTS-1:0] valid_reg;
    obj_word_t              rd_word_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_comb
    begin
        rd_word = rd_word_reg;
        if (!rd_valid_reg)
        begin
            rd_word.skip_count   = '0;
            rd_word.sample_count = '0;
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the constant-velocity track predictor core.
`timescale 1ns / 100ps

module testbench;
    import cvtp_pkg::*;

    localparam int MAX_OBJECTS = MAX_OBJECTS_DEFAULT;
    localparam int SETTLE_CYCLES = 160;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int FIT_SLOTS = 16;
    localparam int PROBE_SLOTS = 32;
    localparam logic [APB_ADDR_W-1:0] KEEP_EVERY_ADDR = APB_ADDR_W'(4 * REG_KEEP_EVERY);
    localparam longint OFS_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint OFS_LO = -OFS_HI - 64'sd1;
    localparam logic [31:0] POS_MIN = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [OBJ_W-1:0] obj;
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
        logic [31:0]      t;
    } pose_t;

    typedef struct packed {
        logic [OBJ_W-1:0] obj;
        logic [1:0]       status;
        logic [47:0]      ofs_x;
        logic [47:0]      ofs_y;
        logic [47:0]      ofs_z;
        logic [31:0]      vel_x;
        logic [31:0]      vel_y;
        logic [31:0]      vel_z;
        logic [31:0]      t_start;
        logic [31:0]      t_end;
    } fit_t;

    typedef struct packed {
        pose_t pose;
        logic  typed;
        fit_t  want;
    } probe_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic sample_valid;
    logic sample_stall;
    logic [OBJ_W-1:0] object_index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] sample_time;
    logic result_valid;
    logic result_stall;
    logic [OBJ_W-1:0] result_object;
    logic [1:0] status;
    logic [47:0] offset_x;
    logic [47:0] offset_y;
    logic [47:0] offset_z;
    logic [31:0] velocity_x;
    logic [31:0] velocity_y;
    logic [31:0] velocity_z;
    logic [31:0] start_time;
    logic [31:0] end_time;

    const_velocity_track_predictor_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .object_index(object_index),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .sample_time(sample_time),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_object(result_object),
        .status(status),
        .offset_x(offset_x),
        .offset_y(offset_y),
        .offset_z(offset_z),
        .velocity_x(velocity_x),
        .velocity_y(velocity_y),
        .velocity_z(velocity_z),
        .start_time(start_time),
        .end_time(end_time)
    );

    logic [KEEP_W-1:0] keep_every_model;
    logic [7:0]  skip_count [MAX_OBJECTS];
    logic [1:0]  kept_count [MAX_OBJECTS];
    logic [31:0] newer_pos [MAX_OBJECTS][3];
    logic [31:0] older_pos [MAX_OBJECTS][3];
    logic [31:0] newer_t [MAX_OBJECTS];
    logic [31:0] older_t [MAX_OBJECTS];

    logic [31:0] track_t [MAX_OBJECTS];
    logic [31:0] track_pos [MAX_OBJECTS][3];

    fit_t pending_fits [FIT_SLOTS];
    int unsigned fit_head;
    int unsigned fit_tail;
    fit_t arrived_want;
    probe_row_t probe_rows [PROBE_SLOTS];
    int unsigned probe_count;
    string check_ctx;
    int unsigned mismatches;
    int unsigned poses_sent;
    int unsigned fits_checked;
    int unsigned fits_by_status [3];
    int unsigned idle_cycles;
    int unsigned stall_hold;
    logic stalling;
    logic calm;
    logic [KEEP_W-1:0] mid_setting;

    function automatic longint fit_velocity(longint rise, longint run);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        num = 64'(rise < 0 ? -rise : rise) << 16;
        den = 64'(run < 0 ? -run : run);
        quo = (num + (den >> 1)) / den;
        if ((rise < 0) != (run < 0)) begin
            if (quo > 64'h8000_0000) quo = 64'h8000_0000;
            return -longint'(quo);
        end
        if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
        return longint'(quo);
    endfunction

    function automatic logic [47:0] fit_offset(longint base, longint vel, logic [31:0] t1);
        logic [63:0] mag;
        longint shift;
        longint sum;
        mag = 64'(vel < 0 ? -vel : vel) * 64'(t1);
        shift = longint'((mag + 64'h8000) >> 16);
        if (vel < 0) shift = -shift;
        sum = base - shift;
        if (sum > OFS_HI) sum = OFS_HI;
        if (sum < OFS_LO) sum = OFS_LO;
        return sum[47:0];
    endfunction

    function automatic bit predict_fit(input pose_t s, output fit_t f);
        logic [7:0]  cnt;
        logic [31:0] in_pos [3];
        logic [31:0] vel [3];
        logic [47:0] ofs [3];
        longint span;
        longint q1;
        longint q2;
        longint v;
        in_pos[0] = s.x;
        in_pos[1] = s.y;
        in_pos[2] = s.z;
        f = '0;
        cnt = skip_count[s.obj];
        if (cnt != 8'hFF) cnt = cnt + 8'd1;
        if (cnt < keep_every_model) begin
            skip_count[s.obj] = cnt;
            return 1'b0;
        end
        skip_count[s.obj] = '0;
        for (int a = 0; a < 3; a++) begin
            older_pos[s.obj][a] = newer_pos[s.obj][a];
            newer_pos[s.obj][a] = in_pos[a];
        end
        older_t[s.obj] = newer_t[s.obj];
        newer_t[s.obj] = s.t;
        if (kept_count[s.obj] != COUNT_FULL) kept_count[s.obj] = kept_count[s.obj] + 2'd1;
        f.obj = s.obj;
        f.t_end = newer_t[s.obj];
        if (kept_count[s.obj] != COUNT_FULL) begin
            f.status = STATUS_ONE_SAMPLE;
            f.t_start = newer_t[s.obj];
            return 1'b1;
        end
        f.t_start = older_t[s.obj];
        if (older_t[s.obj] == newer_t[s.obj]) begin
            f.status = STATUS_EQUAL_TIME;
            return 1'b1;
        end
        f.status = STATUS_OK;
        span = longint'(newer_t[s.obj]) - longint'(older_t[s.obj]);
        for (int a = 0; a < 3; a++) begin
            q1 = longint'($signed(older_pos[s.obj][a]));
            q2 = longint'($signed(newer_pos[s.obj][a]));
            v = fit_velocity(q2 - q1, span);
            vel[a] = v[31:0];
            ofs[a] = fit_offset(q1, v, older_t[s.obj]);
        end
        f.ofs_x = ofs[0];
        f.ofs_y = ofs[1];
        f.ofs_z = ofs[2];
        f.vel_x = vel[0];
        f.vel_y = vel[1];
        f.vel_z = vel[2];
        return 1'b1;
    endfunction

    function automatic fit_t fit_of(logic [OBJ_W-1:0] obj, logic [1:0] st, logic [47:0] ofs,
                                    logic [31:0] vel, logic [31:0] t0, logic [31:0] t1);
        fit_t f;
        f.obj = obj;
        f.status = st;
        f.ofs_x = ofs;
        f.ofs_y = ofs;
        f.ofs_z = ofs;
        f.vel_x = vel;
        f.vel_y = vel;
        f.vel_z = vel;
        f.t_start = t0;
        f.t_end = t1;
        return f;
    endfunction

    function automatic probe_row_t probe(logic [OBJ_W-1:0] obj, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, logic [31:0] t, logic typed,
                                         fit_t want);
        probe_row_t r;
        r.pose.obj = obj;
        r.pose.x = x;
        r.pose.y = y;
        r.pose.z = z;
        r.pose.t = t;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic void add_row(probe_row_t r);
        probe_rows[probe_count] = r;
        probe_count++;
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 19);
        if (roll < 10) return 0;
        if (roll < 18) return $urandom_range(1, 3);
        if (roll < 19) return $urandom_range(4, 12);
        return $urandom_range(20, 150);
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic pose_t next_pose(int unsigned lo, int unsigned hi);
        pose_t s;
        int unsigned roll;
        logic [31:0] in_pos [3];
        s.obj = OBJ_W'($urandom_range(lo, hi));
        roll = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            in_pos[a] = track_pos[s.obj][a] + $urandom_range(0, 32'h4_0000) - 32'h2_0000;
        end
        if (roll <= 5) begin
            s.t = track_t[s.obj] + $urandom_range(1, 32'h3_0000);
        end else if (roll == 6) begin
            s.t = track_t[s.obj];
        end else if (roll == 7) begin
            s.t = track_t[s.obj] - $urandom_range(1, 32'h3_0000);
        end else if (roll == 8) begin
            s.t = $urandom;
            for (int a = 0; a < 3; a++) in_pos[a] = $urandom;
        end else begin
            s.t = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
            for (int a = 0; a < 3; a++) in_pos[a] = pick_extreme();
        end
        s.x = in_pos[0];
        s.y = in_pos[1];
        s.z = in_pos[2];
        track_t[s.obj] = s.t;
        for (int a = 0; a < 3; a++) track_pos[s.obj][a] = in_pos[a];
        return s;
    endfunction

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s %s: expected 'h%0h, got 'h%0h", check_ctx, what, want, got);
            end
        end
    endtask

    task automatic send_pose(pose_t s, logic typed, fit_t want);
        int unsigned gap;
        fit_t predicted;
        gap = pick_idle();
        if (gap > 0) begin
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        object_index <= s.obj;
        pos_x <= s.x;
        pos_y <= s.y;
        pos_z <= s.z;
        sample_time <= s.t;
        do @(posedge clk); while (sample_stall);
        poses_sent++;
        if (predict_fit(s, predicted)) begin
            pending_fits[fit_tail % FIT_SLOTS] = typed ? want : predicted;
            fit_tail++;
        end
    endtask

    task automatic apb_access(input logic write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= KEEP_EVERY_ADDR;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (fit_head != fit_tail) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_keep_every(logic [KEEP_W-1:0] value);
        logic [31:0] rd;
        drain();
        apb_access(1'b1, 32'(value), rd);
        keep_every_model = value;
        apb_access(1'b0, 32'h0, rd);
        check_ctx = "register";
        check_field("keep_every readback", 64'(value), 64'(rd));
    endtask

    task automatic run_random(int unsigned count, int unsigned lo, int unsigned hi);
        for (int unsigned i = 0; i < count; i++) send_pose(next_pose(lo, hi), 1'b0, '0);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        calm = 1'b0;
        forever begin
            repeat ($urandom_range(200, 1200)) @(posedge clk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        result_stall = 1'b0;
        stalling = 1'b0;
        stall_hold = 0;
        forever begin
            @(negedge clk);
            if (stall_hold == 0) begin
                stalling = !stalling && !calm;
                stall_hold = stalling ? pick_idle() : $urandom_range(0, 6);
            end else begin
                stall_hold--;
            end
            result_stall <= stalling;
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (fit_head == fit_tail) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result for object %0d arrived with nothing outstanding",
                             result_object);
                end
            end else begin
                arrived_want = pending_fits[fit_head % FIT_SLOTS];
                fit_head++;
                fits_checked++;
                if (arrived_want.status <= STATUS_EQUAL_TIME) begin
                    fits_by_status[arrived_want.status]++;
                end
                check_ctx = $sformatf("fit %0d (object %0d)", fits_checked, arrived_want.obj);
                check_field("result_object", 64'(arrived_want.obj), 64'(result_object));
                check_field("status", 64'(arrived_want.status), 64'(status));
                check_field("offset_x", 64'(arrived_want.ofs_x), 64'(offset_x));
                check_field("offset_y", 64'(arrived_want.ofs_y), 64'(offset_y));
                check_field("offset_z", 64'(arrived_want.ofs_z), 64'(offset_z));
                check_field("velocity_x", 64'(arrived_want.vel_x), 64'(velocity_x));
                check_field("velocity_y", 64'(arrived_want.vel_y), 64'(velocity_y));
                check_field("velocity_z", 64'(arrived_want.vel_z), 64'(velocity_z));
                check_field("start_time", 64'(arrived_want.t_start), 64'(start_time));
                check_field("end_time", 64'(arrived_want.t_end), 64'(end_time));
            end
        end
    end

    always @(posedge clk) begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no transfer for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] rd;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_valid = 1'b0;
        object_index = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        sample_time = '0;
        idle_cycles = 0;
        mismatches = 0;
        poses_sent = 0;
        fits_checked = 0;
        fit_head = 0;
        fit_tail = 0;
        probe_count = 0;
        fits_by_status = '{0, 0, 0};
        keep_every_model = KEEP_EVERY_RESET;
        for (int i = 0; i < MAX_OBJECTS; i++) begin
            skip_count[i] = '0;
            kept_count[i] = '0;
            newer_t[i] = '0;
            older_t[i] = '0;
            track_t[i] = $urandom;
            for (int a = 0; a < 3; a++) begin
                newer_pos[i][a] = '0;
                older_pos[i][a] = '0;
                track_pos[i][a] = $urandom;
            end
        end

        add_row(probe(0, 0, 0, 0, 32'h0001_0000, 1'b1,
            fit_of(0, STATUS_ONE_SAMPLE, '0, '0, 32'h0001_0000, 32'h0001_0000)));
        add_row(probe(0, 32'h0001_0000, -32'sh1_0000, 32'h0002_0000,
            32'h0002_0000, 1'b0, '0));
        add_row(probe(0, 5, 6, 7, 32'h0002_0000, 1'b1,
            fit_of(0, STATUS_EQUAL_TIME, '0, '0, 32'h0002_0000, 32'h0002_0000)));
        add_row(probe(0, POS_MAX, 0, 32'hFFFF_FFFF, 32'h0000_8000, 1'b0, '0));
        add_row(probe(15, POS_MAX, POS_MAX, POS_MAX, 32'h0, 1'b1,
            fit_of(15, STATUS_ONE_SAMPLE, '0, '0, 32'h0, 32'h0)));
        add_row(probe(15, POS_MIN, POS_MIN, POS_MIN, 32'hFFFF_FFFF, 1'b0, '0));
        add_row(probe(15, 0, 0, 0, 32'hFFFF_FFFF, 1'b1,
            fit_of(15, STATUS_EQUAL_TIME, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF)));
        add_row(probe(15, POS_MAX, POS_MIN, 32'h5555_5555, 32'h1, 1'b0, '0));
        add_row(probe(3, POS_MIN, POS_MIN, POS_MIN, 32'hFFFF_FFFE, 1'b1,
            fit_of(3, STATUS_ONE_SAMPLE, '0, '0, 32'hFFFF_FFFE, 32'hFFFF_FFFE)));
        add_row(probe(4, POS_MAX, POS_MAX, POS_MAX, 32'hFFFF_FFFE, 1'b1,
            fit_of(4, STATUS_ONE_SAMPLE, '0, '0, 32'hFFFF_FFFE, 32'hFFFF_FFFE)));
        add_row(probe(3, POS_MAX, POS_MAX, POS_MAX, 32'hFFFF_FFFF, 1'b1,
            fit_of(3, STATUS_OK, OFS_MIN, VEL_POS_MAX, 32'hFFFF_FFFE, 32'hFFFF_FFFF)));
        add_row(probe(4, POS_MIN, POS_MIN, POS_MIN, 32'hFFFF_FFFF, 1'b1,
            fit_of(4, STATUS_OK, OFS_MAX, VEL_NEG_MAG, 32'hFFFF_FFFE, 32'hFFFF_FFFF)));
        add_row(probe(5, 0, 0, 0, 32'h0, 1'b1,
            fit_of(5, STATUS_ONE_SAMPLE, '0, '0, 32'h0, 32'h0)));
        add_row(probe(5, 1, 32'hFFFF_FFFF, 32'h8000, 32'h0002_0000, 1'b0, '0));
        add_row(probe(5, 32'hAAAA_AAAA, 32'h5555_5555, 0, 32'hDEAD_BEEF,
            1'b0, '0));
        add_row(probe(10, 32'h1234_5678, -32'sd3, 0, 32'h0003_0000, 1'b1,
            fit_of(10, STATUS_ONE_SAMPLE, '0, '0, 32'h0003_0000, 32'h0003_0000)));
        add_row(probe(0, -32'sh1_0000, 32'h0003_0000, 0, 32'h0004_8000,
            1'b0, '0));
        add_row(probe(10, 32'hFFFF_0000, 32'h0000_FFFF, 32'h0F0F_0F0F,
            32'h0000_8000, 1'b0, '0));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_access(1'b0, 32'h0, rd);
        check_ctx = "register";
        check_field("keep_every after reset", 64'(KEEP_EVERY_RESET), 64'(rd));

        for (int unsigned i = 0; i < probe_count; i++) begin
            send_pose(probe_rows[i].pose, probe_rows[i].typed, probe_rows[i].want);
        end

        set_keep_every(8'd0);
        run_random(350, 0, MAX_OBJECTS - 1);
        set_keep_every(8'd3);
        run_random(300, 0, MAX_OBJECTS - 1);
        set_keep_every(8'd255);
        run_random(520, 9, 9);
        mid_setting = KEEP_W'($urandom_range(2, 8));
        set_keep_every(mid_setting);
        run_random(150, 0, MAX_OBJECTS - 1);
        set_keep_every(8'd1);
        run_random(150, 0, MAX_OBJECTS - 1);
        drain();

        $display("%0d poses sent, %0d fits checked: %0d ok, %0d single, %0d equal-time",
                 poses_sent, fits_checked, fits_by_status[0], fits_by_status[1],
                 fits_by_status[2]);
        $display("keep_every run at 1, 0, 3, 255, %0d and 1; %0d mismatches",
                 mid_setting, mismatches);
        if (mismatches == 0 && fit_head == fit_tail) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
